[hw/rtl/bfr_pkg.sv]
// Shared types and constants of the bitstream field reader.
package bfr_pkg;

	// Widths of the item fields.
	localparam int ADDR_W    = 12;
	localparam int BYTE_W    = 8;
	localparam int SBIT_W    = 3;
	localparam int LEN_W     = 6;
	localparam int FIELD_W   = 32;
	localparam int OP_W      = 2;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 48;

	// Operation codes carried in the input tuser.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD     = 2'd0,
		OP_SET_POS  = 2'd1,
		OP_READ_LSB = 2'd2,
		OP_READ_MSB = 2'd3
	} op_t;

	// Sequencer states of the core.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FETCH,
		ST_ALIGN,
		ST_DONE
	} state_t;

	// Strobes from the sequencer to the extraction window.
	typedef struct packed {
		logic push;
		logic msb_first;
		logic shift;
	} ext_ctrl_t;

endpackage

[hw/rtl/bfr_extract.sv]
// Byte window that gathers the spanned bytes, aligns the field bit by bit and masks it.
module bfr_extract #(
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic                                    clk,
	input  bfr_pkg::ext_ctrl_t                      ctrl,
	input  logic [$clog2((MAX_FIELD_BITS+14)/8)-1:0] lane,
	input  logic [bfr_pkg::BYTE_W-1:0]              byte_in,
	input  logic [$clog2(MAX_FIELD_BITS+1)-1:0]     len,
	output logic [bfr_pkg::FIELD_W-1:0]             field
);

	localparam int NB = (MAX_FIELD_BITS + 14) / 8;
	localparam int WW = NB * 8;

	logic [WW-1:0]             win_q;
	logic [MAX_FIELD_BITS-1:0] masked;

	// LSB-first bytes land in their own lane; MSB-first bytes shift in from the bottom.
	// Alignment moves the whole window down one bit per cycle.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (ctrl.msb_first) begin
				win_q <= {win_q[WW-9:0], byte_in};
			end else begin
				win_q[lane*8 +: 8] <= byte_in;
			end
		end else if (ctrl.shift) begin
			win_q <= {1'b0, win_q[WW-1:1]};
		end
	end

	// Keep only the low len bits of the aligned window.
	always_comb begin
		for (int i = 0; i < MAX_FIELD_BITS; i++) begin
			masked[i] = win_q[i] & (i < int'(len));
		end
	end

	generate
		if (MAX_FIELD_BITS >= bfr_pkg::FIELD_W) begin : g_trunc
			assign field = masked[bfr_pkg::FIELD_W-1:0];
		end else begin : g_ext
			assign field = {{(bfr_pkg::FIELD_W-MAX_FIELD_BITS){1'b0}}, masked};
		end
	endgenerate

endmodule

[hw/rtl/bitstream_field_reader_core.sv]
// Top level of the bitstream field reader: byte store, read position and sequencer.
// The core takes one item at a time. A load or a set-position item takes the
// address through a remainder step per cycle (one step when STORE_BYTES is at
// least 4096). A read of n bits from bit offset b fetches k = ceil((b+n)/8)
// bytes through the single port of the byte memory, one a cycle, with a
// registered read, then aligns the field one bit a cycle over s shifts
// (s = b for LSB-first, s = (8 - (b+n) mod 8) mod 8 for MSB-first). A
// zero-length read skips the memory. The result waits in an output register;
// the core only stalls when a second result is ready before the first has been
// taken. The byte memory has no reset and no clearing pass: reading a byte
// never loaded is undefined.
module bitstream_field_reader_core #(
	parameter int STORE_BYTES    = 4096,
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// address[11:0], byte_value[19:12], start_bit[22:20], field_length[28:23], zeros
	input  logic [bfr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// operation[1:0]
	input  logic [bfr_pkg::OP_W-1:0]        s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// field_value[31:0], byte_position[43:32], bit_position[46:44], zero
	output logic [bfr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	localparam int AW     = $clog2(STORE_BYTES);
	localparam int CW     = ((AW > bfr_pkg::ADDR_W) ? AW : bfr_pkg::ADDR_W) + 1;
	localparam int KMAX   = (AW >= bfr_pkg::ADDR_W) ? 0 : bfr_pkg::ADDR_W - AW;
	localparam int KW     = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
	localparam int LW     = $clog2(MAX_FIELD_BITS + 1);
	localparam int TW     = $clog2(MAX_FIELD_BITS + 8);
	localparam int NB     = (MAX_FIELD_BITS + 14) / 8;
	localparam int NBW    = $clog2(NB + 1);
	localparam int LANE_W = $clog2(NB);

	// Sequencer and item registers.
	bfr_pkg::state_t                state_q, state_d;
	bfr_pkg::op_t                   op_q;
	logic [CW-1:0]                  rem_q;
	logic [bfr_pkg::BYTE_W-1:0]     byte_q;
	logic [bfr_pkg::SBIT_W-1:0]     sbit_q;
	logic [LW-1:0]                  len_q;
	logic [TW-1:0]                  total_q;
	logic [NBW-1:0]                 nbytes_q;
	logic [NBW-1:0]                 iss_q;
	logic [KW-1:0]                  red_q;
	logic [2:0]                     sh_q;
	logic [AW-1:0]                  fa_q;
	logic [AW-1:0]                  ptr_q;
	logic [bfr_pkg::SBIT_W-1:0]     boff_q;

	// Memory read stage.
	logic [bfr_pkg::BYTE_W-1:0]     store_q [STORE_BYTES];
	logic [bfr_pkg::BYTE_W-1:0]     rdata_s1;
	logic                           rvalid_s1;
	logic [LANE_W-1:0]              lane_s1;

	// Output register.
	logic                           out_valid_q;
	logic [bfr_pkg::FIELD_W-1:0]    out_field_q;
	logic [bfr_pkg::ADDR_W-1:0]     out_bpos_q;
	logic [bfr_pkg::SBIT_W-1:0]     out_boff_q;

	// Strobes.
	logic                           take;
	logic                           issue;
	logic                           shift;
	logic                           finish;
	logic                           mem_we;
	bfr_pkg::ext_ctrl_t             ext_ctrl;
	logic [bfr_pkg::FIELD_W-1:0]    ext_field;

	// Input fields.
	bfr_pkg::op_t                   in_op;
	logic [bfr_pkg::ADDR_W-1:0]     in_addr;
	logic [bfr_pkg::BYTE_W-1:0]     in_byte;
	logic [bfr_pkg::SBIT_W-1:0]     in_sbit;
	logic [bfr_pkg::LEN_W-1:0]      in_len;
	logic [LW-1:0]                  len_sat;
	logic [TW-1:0]                  total_in;
	logic [TW:0]                    total_rnd;

	// Arithmetic on addresses and position.
	logic [CW-1:0]                  divisor;
	logic [AW:0]                    fa_inc;
	logic [AW-1:0]                  fa_next;
	logic [AW:0]                    psum;
	logic [AW-1:0]                  ptr_adv;
	logic [AW-1:0]                  ptr_new;
	logic [bfr_pkg::SBIT_W-1:0]     boff_new;
	logic [CW-1:0]                  ptr_ext;

	assign in_op   = bfr_pkg::op_t'(s_axis_tuser);
	assign in_addr = s_axis_tdata[11:0];
	assign in_byte = s_axis_tdata[19:12];
	assign in_sbit = s_axis_tdata[22:20];
	assign in_len  = s_axis_tdata[28:23];

	// Lengths above the widest field saturate; the bit total sets the byte count.
	assign len_sat   = (int'(in_len) > MAX_FIELD_BITS) ? LW'(MAX_FIELD_BITS) : LW'(in_len);
	assign total_in  = TW'(boff_q) + TW'(len_sat);
	assign total_rnd = {1'b0, total_in} + (TW+1)'(7);

	// One step of the address remainder: subtract the store size scaled by 2^red_q.
	assign divisor = CW'(STORE_BYTES) << red_q;

	// Fetch address and pointer advance, both wrapping at the store size.
	assign fa_inc  = {1'b0, fa_q} + (AW+1)'(1);
	assign fa_next = (fa_inc == (AW+1)'(STORE_BYTES)) ? '0 : fa_inc[AW-1:0];
	assign psum    = {1'b0, ptr_q} + (AW+1)'(total_q[TW-1:3]);
	assign ptr_adv = (psum >= (AW+1)'(STORE_BYTES)) ?
		AW'(psum - (AW+1)'(STORE_BYTES)) : psum[AW-1:0];

	// Position after the current item.
	always_comb begin
		ptr_new  = ptr_q;
		boff_new = boff_q;
		case (op_q)
			bfr_pkg::OP_SET_POS: begin
				ptr_new  = rem_q[AW-1:0];
				boff_new = sbit_q;
			end
			bfr_pkg::OP_READ_LSB, bfr_pkg::OP_READ_MSB: begin
				ptr_new  = ptr_adv;
				boff_new = total_q[2:0];
			end
			default: begin
			end
		endcase
	end

	assign ptr_ext = CW'(ptr_new);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d = state_q;
		take    = 1'b0;
		issue   = 1'b0;
		shift   = 1'b0;
		finish  = 1'b0;
		case (state_q)
			bfr_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					take = 1'b1;
					if (in_op == bfr_pkg::OP_LOAD || in_op == bfr_pkg::OP_SET_POS) begin
						state_d = bfr_pkg::ST_REDUCE;
					end else if (len_sat == '0) begin
						state_d = bfr_pkg::ST_DONE;
					end else begin
						state_d = bfr_pkg::ST_FETCH;
					end
				end
			end
			bfr_pkg::ST_REDUCE: begin
				if (red_q == '0) begin
					state_d = bfr_pkg::ST_DONE;
				end
			end
			bfr_pkg::ST_FETCH: begin
				issue = (iss_q != nbytes_q);
				if (rvalid_s1 && (NBW'(lane_s1) + NBW'(1) == nbytes_q)) begin
					state_d = bfr_pkg::ST_ALIGN;
				end
			end
			bfr_pkg::ST_ALIGN: begin
				if (sh_q == '0) begin
					state_d = bfr_pkg::ST_DONE;
				end else begin
					shift = 1'b1;
				end
			end
			bfr_pkg::ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					finish  = 1'b1;
					state_d = bfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfr_pkg::ST_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == bfr_pkg::ST_IDLE);
	assign mem_we        = finish && (op_q == bfr_pkg::OP_LOAD);

	// Item registers: captured on acceptance, then stepped by the sequencer.
	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= in_op;
			rem_q    <= CW'(in_addr);
			byte_q   <= in_byte;
			sbit_q   <= in_sbit;
			len_q    <= len_sat;
			total_q  <= total_in;
			nbytes_q <= NBW'(total_rnd >> 3);
			iss_q    <= '0;
			red_q    <= KW'(KMAX);
			fa_q     <= ptr_q;
			sh_q     <= (in_op == bfr_pkg::OP_READ_MSB) ? 3'(3'd0 - total_in[2:0]) : boff_q;
		end else begin
			if (state_q == bfr_pkg::ST_REDUCE) begin
				if (rem_q >= divisor) begin
					rem_q <= rem_q - divisor;
				end
				if (red_q != '0) begin
					red_q <= red_q - KW'(1);
				end
			end
			if (issue) begin
				iss_q <= iss_q + NBW'(1);
				fa_q  <= fa_next;
			end
			if (shift) begin
				sh_q <= sh_q - 3'd1;
			end
		end
	end

	// Byte memory: one write on a finished load, one read per issued fetch.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[rem_q[AW-1:0]] <= byte_q;
		end
		if (issue) begin
			rdata_s1 <= store_q[fa_q];
			lane_s1  <= iss_q[LANE_W-1:0];
		end
	end

	// Read-valid flag and the architectural position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
			ptr_q     <= '0;
			boff_q    <= '0;
		end else begin
			rvalid_s1 <= issue;
			if (finish) begin
				ptr_q  <= ptr_new;
				boff_q <= boff_new;
			end
		end
	end

	// Extraction window.
	assign ext_ctrl.push      = rvalid_s1;
	assign ext_ctrl.msb_first = (op_q == bfr_pkg::OP_READ_MSB);
	assign ext_ctrl.shift     = shift;

	bfr_extract #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_extract (
		.clk     (clk),
		.ctrl    (ext_ctrl),
		.lane    (lane_s1),
		.byte_in (rdata_s1),
		.len     (len_q),
		.field   (ext_field)
	);

	// Output register: the result item waits here until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_field_q <= (op_q == bfr_pkg::OP_READ_LSB || op_q == bfr_pkg::OP_READ_MSB) ?
				ext_field : '0;
			out_bpos_q  <= ptr_ext[bfr_pkg::ADDR_W-1:0];
			out_boff_q  <= boff_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_boff_q, out_bpos_q, out_field_q};

endmodule

[hw/rtl/bfr_checker.sv]
// Port-level checks of the bitstream field reader, bound to the top level.
module bfr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [bfr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	// The core works on one item at a time: it is busy right after an acceptance.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item was still in work");

	// A stalled result keeps its valid and its contents.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed or vanished");

	// A fresh result comes with the core free for the next item.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("new result while the core is still busy");

	// The padding bit of the result is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[bfr_pkg::M_TDATA_W-1] == 1'b0))
		else $error("result padding bit set");

endmodule

bind bitstream_field_reader_core bfr_checker u_bfr_checker (.*);
